FILE: design/assert_macros.svh
// Assertion macros used by the checker module of the cave filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define CAGF_CHK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define CAGF_CHK_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cagf_pkg.sv
// Shared constants, types and the neighbor count function of the cave filter.
package cagf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int CFG_W         = 11;
  localparam int LIM_W         = 4;
  localparam int ROW_W         = 11;
  localparam int HM1_W         = 10;
  localparam int CNT_W         = 4;
  localparam int WIN_W         = 9;

  localparam int WIDTH_RST  = 64;
  localparam int HEIGHT_RST = 64;
  localparam int DEATH_RST  = 3;
  localparam int BIRTH_RST  = 4;

  localparam logic FUNC_CELL  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_DEATH_LIMIT  = 2'd2,
    CFG_BIRTH_LIMIT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic emit;
    logic edge_l;
    logic edge_r;
    logic edge_t;
    logic edge_b;
    logic last;
  } cagf_flags_t;

  function automatic logic [CNT_W-1:0] nbr_count(input logic [WIN_W-1:0] win,
                                                 input cagf_flags_t   f);
    logic [CNT_W-1:0] cnt;
    logic             outside;
    cnt = '0;
    for (int k = 0; k < WIN_W; k++) begin
      if (k != 4) begin
        outside = ((k < 3) && f.edge_l) || ((k > 5) && f.edge_r) ||
                  ((k == 0 || k == 3 || k == 6) && f.edge_t) ||
                  ((k == 2 || k == 5 || k == 8) && f.edge_b);
        cnt = cnt + {{(CNT_W-1){1'b0}}, outside | win[k]};
      end
    end
    return cnt;
  endfunction

endpackage

FILE: design/cagf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cagf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/cagf_seq.sv
// Input sequencer: raster counters, drain handling and per-item edge flags.
module cagf_seq import cagf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_func,
  input  logic                         in_cell_in,
  input  logic                         s1_rdy,
  input  logic                         restart,
  input  logic [$clog2(MAX_WIDTH)-1:0] wm1,
  input  logic [HM1_W-1:0]             hm1,
  output logic                         take,
  output logic                         take_cell,
  output logic [$clog2(MAX_WIDTH)-1:0] take_col,
  output cagf_flags_t                  take_flags
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]    pc_r, pc_nxt;
  logic [HM1_W-1:0] pr_r, pr_nxt;
  logic             flushing;
  logic             is_cell;
  cagf_flags_t      flags;

  assign flushing = in_row_r > {{(ROW_W-HM1_W){1'b0}}, hm1};
  assign is_cell  = (in_func == FUNC_CELL);

  assign flags.emit   = !((in_row_r == '0) ||
                          (in_row_r == ROW_W'(1) && in_col_r == '0));
  assign flags.edge_l = (pc_r == '0);
  assign flags.edge_r = (pc_r == wm1);
  assign flags.edge_t = (pr_r == '0);
  assign flags.edge_b = (pr_r == hm1);
  assign flags.last   = flags.edge_r && flags.edge_b;

  assign take       = in_valid && s1_rdy && (is_cell || flushing);
  assign take_cell  = is_cell && !flushing && in_cell_in;
  assign take_col   = in_col_r;
  assign take_flags = flags;

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    pc_nxt     = pc_r;
    pr_nxt     = pr_r;
    if (restart) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      pc_nxt     = '0;
      pr_nxt     = '0;
    end else if (take) begin
      if (in_col_r == wm1) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (flags.emit) begin
        if (flags.last) begin
          in_col_nxt = '0;
          in_row_nxt = '0;
          pc_nxt     = '0;
          pr_nxt     = '0;
        end else if (flags.edge_r) begin
          pc_nxt = '0;
          pr_nxt = pr_r + HM1_W'(1);
        end else begin
          pc_nxt = pc_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      pc_r     <= '0;
      pr_r     <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      pc_r     <= pc_nxt;
      pr_r     <= pr_nxt;
    end
  end

endmodule

FILE: design/cagf_nbr.sv
// Row store read, forwarding and 3x3 window stages of the cave filter.
module cagf_nbr import cagf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_load,
  input  logic                         up_cell,
  input  logic [$clog2(MAX_WIDTH)-1:0] up_col,
  input  cagf_flags_t                  up_flags,
  output logic                         up_rdy,
  input  logic                         dn_rdy,
  output logic                         dn_valid,
  output logic [WIN_W-1:0]             dn_win,
  output cagf_flags_t                  dn_flags
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic             s1_v_r, s1_v_nxt;
  logic             s1_cell_r;
  logic [CW-1:0]    s1_col_r;
  cagf_flags_t      s1_flags_r;
  logic             fwd_r, fwd_nxt;
  logic [1:0]       fwd_dat_r;
  logic             s2_v_r, s2_v_nxt;
  logic [WIN_W-1:0] s2_win_r;
  cagf_flags_t      s2_flags_r;
  logic [WIN_W-1:0] window_r, window_nxt;
  logic [1:0]       ram_q;
  logic [1:0]       rows;
  logic             s2_rdy;
  logic             s1_adv;

  // Each word holds the row two above in bit 0 and the row above in bit 1.
  cagf_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ({s1_cell_r, rows[1]}),
    .rd_en   (up_load),
    .rd_addr (up_col),
    .rd_data (ram_q)
  );

  assign rows       = fwd_r ? fwd_dat_r : ram_q;
  assign s2_rdy     = !s2_v_r || dn_rdy;
  assign s1_adv     = s1_v_r && s2_rdy;
  assign up_rdy     = !s1_v_r || s2_rdy;
  assign window_nxt = {s1_cell_r, rows[1], rows[0], window_r[WIN_W-1:3]};
  assign fwd_nxt    = s1_adv && (s1_col_r == up_col);
  assign s1_v_nxt   = up_load ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign s2_v_nxt   = s1_adv ? 1'b1 : ((s2_v_r && dn_rdy) ? 1'b0 : s2_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      fwd_r    <= 1'b0;
      window_r <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      if (up_load) begin
        fwd_r <= fwd_nxt;
      end
      if (s1_adv) begin
        window_r <= window_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_load) begin
      s1_cell_r  <= up_cell;
      s1_col_r   <= up_col;
      s1_flags_r <= up_flags;
      fwd_dat_r  <= {s1_cell_r, rows[1]};
    end
    if (s1_adv) begin
      s2_win_r   <= window_nxt;
      s2_flags_r <= s1_flags_r;
    end
  end

  assign dn_valid = s2_v_r;
  assign dn_win   = s2_win_r;
  assign dn_flags = s2_flags_r;

endmodule

FILE: design/cagf_rule.sv
// Neighbor count, survival rule and result register of the cave filter.
module cagf_rule import cagf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  logic [WIN_W-1:0] up_win,
  input  cagf_flags_t      up_flags,
  output logic             up_rdy,
  input  logic [LIM_W-1:0] death_limit,
  input  logic [LIM_W-1:0] birth_limit,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_cell_out,
  output logic             out_frame_end
);

  logic             s3_v_r, s3_v_nxt;
  logic [CNT_W-1:0] s3_cnt_r;
  logic             s3_ctr_r;
  logic             s3_emit_r;
  logic             s3_last_r;
  logic             out_v_r, out_v_nxt;
  logic             out_cell_r;
  logic             out_end_r;
  logic             out_rdy;
  logic             s3_rdy;
  logic             s3_adv;
  logic             s3_load;
  logic             solid;

  assign out_rdy = !out_v_r || !out_stall;
  assign s3_rdy  = !s3_v_r || out_rdy;
  assign s3_adv  = s3_v_r && out_rdy;
  assign s3_load = up_valid && s3_rdy;
  assign up_rdy  = s3_rdy;

  assign solid = s3_ctr_r ? !(s3_cnt_r < CNT_W'(death_limit))
                          : (s3_cnt_r > CNT_W'(birth_limit));

  assign s3_v_nxt  = s3_load ? 1'b1 : (s3_adv ? 1'b0 : s3_v_r);
  assign out_v_nxt = (s3_adv && s3_emit_r) || (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_cnt_r  <= nbr_count(up_win, up_flags);
      s3_ctr_r  <= up_win[4];
      s3_emit_r <= up_flags.emit;
      s3_last_r <= up_flags.last;
    end
    if (s3_adv && s3_emit_r) begin
      out_cell_r <= solid;
      out_end_r  <= s3_last_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_cell_out  = out_cell_r;
  assign out_frame_end = out_end_r;

endmodule

FILE: design/cave_automaton_generation_filter_unit.sv
// Top level of the cave-smoothing cellular automaton generation filter.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_func, in_cell_in
//   out      output     out_valid/out_stall  out_cell_out, out_frame_end
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request is taken every clock while in_stall is low; a request passes through the row store
// read, window, count and rule stages into the result register.
// Results trail the cell stream by one grid row plus one cell; drain requests flush them.
// Reset is synchronous; the row store holds no reset and needs no clearing pass.
// A stalled result backs up the four elastic stages, and in_stall rises only when
// all of them are full.
module cave_automaton_generation_filter_unit import cagf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic             in_cell_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_cell_out,
  output logic             out_frame_end,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int CMPW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int WM1_RST = ((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST) - 1;

  logic [CW-1:0]    wm1_r, wm1_nxt;
  logic [HM1_W-1:0] hm1_r, hm1_nxt;
  logic [LIM_W-1:0] death_r;
  logic [LIM_W-1:0] birth_r;
  logic [CMPW-1:0]  fw_ext;
  logic             cfg_wr;
  logic             restart;
  logic             s1_rdy;
  logic             take;
  logic             take_cell;
  logic [CW-1:0]    take_col;
  cagf_flags_t      take_flags;
  logic             s2_valid;
  logic [WIN_W-1:0] s2_win;
  cagf_flags_t      s2_flags;
  logic             s3_rdy;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_idx_t'(cfg_index) == CFG_FRAME_WIDTH ||
                                cfg_idx_t'(cfg_index) == CFG_FRAME_HEIGHT);
  assign fw_ext    = CMPW'(cfg_data);

  always_comb begin
    if (fw_ext == '0) begin
      wm1_nxt = '0;
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      wm1_nxt = CW'(MAX_WIDTH - 1);
    end else begin
      wm1_nxt = CW'(fw_ext - CMPW'(1));
    end
    if (cfg_data == '0) begin
      hm1_nxt = '0;
    end else if (cfg_data > CFG_W'(MAX_HEIGHT)) begin
      hm1_nxt = HM1_W'(MAX_HEIGHT - 1);
    end else begin
      hm1_nxt = HM1_W'(cfg_data - CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r   <= CW'(WM1_RST);
      hm1_r   <= HM1_W'(HEIGHT_RST - 1);
      death_r <= LIM_W'(DEATH_RST);
      birth_r <= LIM_W'(BIRTH_RST);
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  wm1_r   <= wm1_nxt;
        CFG_FRAME_HEIGHT: hm1_r   <= hm1_nxt;
        CFG_DEATH_LIMIT:  death_r <= cfg_data[LIM_W-1:0];
        CFG_BIRTH_LIMIT:  birth_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !s1_rdy;

  cagf_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_func    (in_func),
    .in_cell_in (in_cell_in),
    .s1_rdy     (s1_rdy),
    .restart    (restart),
    .wm1        (wm1_r),
    .hm1        (hm1_r),
    .take       (take),
    .take_cell  (take_cell),
    .take_col   (take_col),
    .take_flags (take_flags)
  );

  cagf_nbr #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_nbr (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_load  (take),
    .up_cell  (take_cell),
    .up_col   (take_col),
    .up_flags (take_flags),
    .up_rdy   (s1_rdy),
    .dn_rdy   (s3_rdy),
    .dn_valid (s2_valid),
    .dn_win   (s2_win),
    .dn_flags (s2_flags)
  );

  cagf_rule u_rule (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (s2_valid),
    .up_win        (s2_win),
    .up_flags      (s2_flags),
    .up_rdy        (s3_rdy),
    .death_limit   (death_r),
    .birth_limit   (birth_r),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_cell_out  (out_cell_out),
    .out_frame_end (out_frame_end)
  );

endmodule

FILE: design/cagf_chk.sv
// Port-level assertion checker for the cave filter and its bind statement.
`include "assert_macros.svh"

module cagf_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_cell_out,
  input logic out_frame_end,
  input logic cfg_ready
);

  `CAGF_CHK_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_cell_out) && $stable(out_frame_end), "Stalled result changed.")
  `CAGF_CHK_IMP(a_stall_full, in_stall, out_valid && out_stall, "Input stalled while the result side was free.")
  `CAGF_CHK_NXT(a_stall_keep, in_stall && out_stall, in_stall || !out_stall, "Full pipeline drained under a result stall.")
  `CAGF_CHK_IMP(a_cfg_open, in_valid || !in_valid, cfg_ready, "Configuration port refused a write.")

endmodule

bind cave_automaton_generation_filter_unit cagf_chk u_cagf_chk (.*);
